// ===== rtl/lshs_pkg.sv =====
// Shared types and constants for the limit switch homing sequencer.
// Used by lshs_step and limit_switch_homing_sequencer_core.
`timescale 1ns / 1ps

package lshs_pkg;

  localparam int POS_WIDTH   = 24;
  localparam int COUNT_WIDTH = 16;
  localparam int SPEED_WIDTH = 8;
  localparam int TICKS_WIDTH = 16;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_ADDR_WIDTH = 2;

  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SEEK_SPEED    = 2'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SLOW_SPEED    = 2'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_BACKOFF_TICKS = 2'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_BACKOFF_SPEED = 2'd3;

  typedef enum logic [2:0] {
    G_NONE  = 3'd0,
    G_LEFT  = 3'd1,
    G_RIGHT = 3'd2,
    G_UP    = 3'd3,
    G_DOWN  = 3'd4
  } guard_t;

  typedef enum logic [4:0] {
    PH_IDLE        = 5'd0,
    PH_SEEK_L_FAST = 5'd1,
    PH_BACK_R      = 5'd2,
    PH_SEEK_D_FAST = 5'd3,
    PH_BACK_U      = 5'd4,
    PH_SEEK_D_SLOW = 5'd5,
    PH_SEEK_L_SLOW = 5'd6,
    PH_BACK_R2     = 5'd7,
    PH_BACK_U2     = 5'd8,
    PH_ORIGIN      = 5'd9,
    PH_BACK_U3     = 5'd10,
    PH_SEEK_R_FAST = 5'd11,
    PH_BACK_L      = 5'd12,
    PH_SEEK_R_SLOW = 5'd13,
    PH_BACK_L2     = 5'd14,
    PH_SEEK_U_FAST = 5'd15,
    PH_BACK_D      = 5'd16,
    PH_SEEK_U_SLOW = 5'd17,
    PH_BACK_D2     = 5'd18,
    PH_FINISH      = 5'd19,
    PH_DONE        = 5'd20
  } phase_t;

  typedef struct packed {
    logic                   dir;
    logic [SPEED_WIDTH-1:0] drive;
  } motor_cmd_t;

  typedef struct packed {
    logic [SPEED_WIDTH-1:0] seek_speed;
    logic [SPEED_WIDTH-1:0] slow_speed;
    logic [TICKS_WIDTH-1:0] backoff_ticks;
    logic [SPEED_WIDTH-1:0] backoff_speed;
  } lshs_cfg_t;

  typedef struct packed {
    phase_t                      phase;
    logic [COUNT_WIDTH-1:0]      count;
    logic                        timer_idle;
    motor_cmd_t                  cmd_a;
    motor_cmd_t                  cmd_b;
    guard_t                      guard_one;
    guard_t                      guard_two;
    logic signed [POS_WIDTH-1:0] bound_right;
    logic signed [POS_WIDTH-1:0] bound_top;
  } lshs_state_t;

endpackage

// ===== rtl/lshs_step.sv =====
// Next-state logic for one sequencer step of the homing sequencer.
// Depends on lshs_pkg for the state, config and code types.
`timescale 1ns / 1ps

module lshs_step (
  input  lshs_pkg::lshs_state_t          cur,
  input  lshs_pkg::lshs_cfg_t            cfg,
  input  logic                           op,
  input  logic                           tick,
  input  logic                           sw_left,
  input  logic                           sw_right,
  input  logic                           sw_top,
  input  logic                           sw_bottom,
  input  logic signed [lshs_pkg::POS_WIDTH-1:0] enc_a,
  input  logic signed [lshs_pkg::POS_WIDTH-1:0] enc_b,
  output lshs_pkg::lshs_state_t          nxt,
  output logic                           zero_enc
);
  import lshs_pkg::*;

  function automatic lshs_state_t drive_toward(input lshs_state_t s, input guard_t tgt,
                                               input logic [SPEED_WIDTH-1:0] speed);
    lshs_state_t r;
    r = s;
    r.cmd_a.dir   = (tgt == G_RIGHT) || (tgt == G_UP);
    r.cmd_b.dir   = (tgt == G_LEFT) || (tgt == G_UP);
    r.cmd_a.drive = speed;
    r.cmd_b.drive = speed;
    return r;
  endfunction

  function automatic lshs_state_t retreat(input lshs_state_t s, input guard_t tgt,
                                          input lshs_cfg_t c, output logic done);
    lshs_state_t r;
    r = s;
    if (r.timer_idle) begin
      r.timer_idle = 1'b0;
      r.count      = '0;
    end
    if (r.count >= c.backoff_ticks) begin
      r.timer_idle  = 1'b1;
      r.cmd_a.drive = '0;
      r.cmd_b.drive = '0;
      done = 1'b1;
    end else begin
      r    = drive_toward(r, tgt, c.backoff_speed);
      done = 1'b0;
    end
    return r;
  endfunction

  function automatic lshs_state_t seek(input lshs_state_t s, input logic pressed,
                                       input guard_t g1, input guard_t g2, input guard_t tgt,
                                       input logic [SPEED_WIDTH-1:0] speed,
                                       output logic done);
    lshs_state_t r;
    r = s;
    r.guard_one = g1;
    r.guard_two = g2;
    done = pressed;
    if (!pressed) r = drive_toward(r, tgt, speed);
    return r;
  endfunction

  logic signed [POS_WIDTH:0] sum_ab;
  logic signed [POS_WIDTH:0] diff_ab;

  assign sum_ab  = {enc_a[POS_WIDTH-1], enc_a} + {enc_b[POS_WIDTH-1], enc_b};
  assign diff_ab = {enc_a[POS_WIDTH-1], enc_a} - {enc_b[POS_WIDTH-1], enc_b};

  always_comb begin
    lshs_state_t s;
    logic        done;
    s        = cur;
    done     = 1'b0;
    zero_enc = 1'b0;
    if (tick && (cur.count != {COUNT_WIDTH{1'b1}})) s.count = cur.count + 1'b1;

    if (op) begin
      // each pressed switch in turn; the last one wins
      if (sw_left) begin
        s.guard_one = G_LEFT;
        s = retreat(s, G_RIGHT, cfg, done);
      end
      if (sw_right) begin
        s.guard_one = G_RIGHT;
        s = retreat(s, G_LEFT, cfg, done);
      end
      if (sw_top) begin
        s.guard_one = G_UP;
        s = retreat(s, G_DOWN, cfg, done);
      end
      if (sw_bottom) begin
        s.guard_one = G_DOWN;
        s = retreat(s, G_UP, cfg, done);
      end
      s.phase = PH_SEEK_L_FAST;
    end else begin
      unique case (cur.phase)
        PH_SEEK_L_FAST: begin
          s = seek(s, sw_left, G_LEFT, G_NONE, G_LEFT, cfg.seek_speed, done);
          if (done) s.phase = PH_BACK_R;
        end
        PH_BACK_R: begin
          s = retreat(s, G_RIGHT, cfg, done);
          if (done) s.phase = PH_SEEK_D_FAST;
        end
        PH_SEEK_D_FAST: begin
          s = seek(s, sw_bottom, G_DOWN, G_NONE, G_DOWN, cfg.seek_speed, done);
          if (done) s.phase = PH_BACK_U;
        end
        PH_BACK_U: begin
          s = retreat(s, G_UP, cfg, done);
          if (done) s.phase = PH_SEEK_D_SLOW;
        end
        PH_SEEK_D_SLOW: begin
          s = seek(s, sw_bottom, G_DOWN, G_NONE, G_DOWN, cfg.slow_speed, done);
          if (done) s.phase = PH_SEEK_L_SLOW;
        end
        PH_SEEK_L_SLOW: begin
          s = seek(s, sw_left, G_LEFT, G_DOWN, G_LEFT, cfg.slow_speed, done);
          if (done) s.phase = PH_BACK_R2;
        end
        PH_BACK_R2: begin
          s = retreat(s, G_RIGHT, cfg, done);
          if (done) s.phase = PH_BACK_U2;
        end
        PH_BACK_U2: begin
          s = retreat(s, G_UP, cfg, done);
          if (done) s.phase = PH_ORIGIN;
        end
        PH_ORIGIN: begin
          zero_enc = 1'b1;
          s.phase  = PH_BACK_U3;
        end
        PH_BACK_U3: begin
          s = retreat(s, G_UP, cfg, done);
          if (done) s.phase = PH_SEEK_R_FAST;
        end
        PH_SEEK_R_FAST: begin
          s = seek(s, sw_right, G_RIGHT, G_NONE, G_RIGHT, cfg.seek_speed, done);
          if (done) s.phase = PH_BACK_L;
        end
        PH_BACK_L: begin
          s = retreat(s, G_LEFT, cfg, done);
          if (done) s.phase = PH_SEEK_R_SLOW;
        end
        PH_SEEK_R_SLOW: begin
          s = seek(s, sw_right, G_RIGHT, G_NONE, G_RIGHT, cfg.slow_speed, done);
          if (done) begin
            s.bound_right = sum_ab[POS_WIDTH:1];
            s.phase       = PH_BACK_L2;
          end
        end
        PH_BACK_L2: begin
          s = retreat(s, G_LEFT, cfg, done);
          if (done) s.phase = PH_SEEK_U_FAST;
        end
        PH_SEEK_U_FAST: begin
          s = seek(s, sw_top, G_UP, G_NONE, G_UP, cfg.seek_speed, done);
          if (done) s.phase = PH_BACK_D;
        end
        PH_BACK_D: begin
          s = retreat(s, G_DOWN, cfg, done);
          if (done) s.phase = PH_SEEK_U_SLOW;
        end
        PH_SEEK_U_SLOW: begin
          s = seek(s, sw_top, G_UP, G_NONE, G_UP, cfg.slow_speed, done);
          if (done) begin
            s.bound_top = diff_ab[POS_WIDTH:1];
            s.phase     = PH_BACK_D2;
          end
        end
        PH_BACK_D2: begin
          s = retreat(s, G_DOWN, cfg, done);
          if (done) begin
            s.phase     = PH_FINISH;
            s.guard_one = G_NONE;
            s.guard_two = G_NONE;
          end
        end
        PH_FINISH: s.phase = PH_DONE;
        default: ;
      endcase
    end
    nxt = s;
  end

endmodule

// ===== rtl/limit_switch_homing_sequencer_core.sv =====
// The result word is registered and valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while out_ready is high; the result register frees as it is taken.
// Reset (rst_n low, synchronous): phase idle, timer free, motors stopped,
// guards none, bounds zero, config back to seek 200, slow 160, ticks 100,
// backoff 200. Depends on lshs_pkg and lshs_step.
`timescale 1ns / 1ps

module limit_switch_homing_sequencer_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [lshs_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
  input  logic [lshs_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic                                  in_tick,
  input  logic                                  in_sw_left,
  input  logic                                  in_sw_right,
  input  logic                                  in_sw_top,
  input  logic                                  in_sw_bottom,
  input  logic signed [lshs_pkg::POS_WIDTH-1:0] in_enc_a,
  input  logic signed [lshs_pkg::POS_WIDTH-1:0] in_enc_b,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lshs_pkg::SPEED_WIDTH-1:0]      out_drive_a,
  output logic                                  out_dir_a,
  output logic [lshs_pkg::SPEED_WIDTH-1:0]      out_drive_b,
  output logic                                  out_dir_b,
  output logic                                  out_zero_encoders,
  output logic [4:0]                            out_phase,
  output logic [2:0]                            out_guard_one,
  output logic [2:0]                            out_guard_two,
  output logic signed [lshs_pkg::POS_WIDTH-1:0] out_right_limit,
  output logic signed [lshs_pkg::POS_WIDTH-1:0] out_top_limit,
  output logic                                  out_finished
);
  import lshs_pkg::*;

  lshs_cfg_t   cfg_r;
  lshs_state_t state_r;
  lshs_state_t state_nxt;
  logic        zero_r;
  logic        zero_nxt;
  logic        out_valid_r;
  logic        in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  lshs_step u_step (
    .cur       (state_r),
    .cfg       (cfg_r),
    .op        (in_op),
    .tick      (in_tick),
    .sw_left   (in_sw_left),
    .sw_right  (in_sw_right),
    .sw_top    (in_sw_top),
    .sw_bottom (in_sw_bottom),
    .enc_a     (in_enc_a),
    .enc_b     (in_enc_b),
    .nxt       (state_nxt),
    .zero_enc  (zero_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seek_speed    <= SPEED_WIDTH'(200);
      cfg_r.slow_speed    <= SPEED_WIDTH'(160);
      cfg_r.backoff_ticks <= TICKS_WIDTH'(100);
      cfg_r.backoff_speed <= SPEED_WIDTH'(200);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SEEK_SPEED:    cfg_r.seek_speed    <= cfg_wdata[SPEED_WIDTH-1:0];
        CFG_SLOW_SPEED:    cfg_r.slow_speed    <= cfg_wdata[SPEED_WIDTH-1:0];
        CFG_BACKOFF_TICKS: cfg_r.backoff_ticks <= cfg_wdata[TICKS_WIDTH-1:0];
        CFG_BACKOFF_SPEED: cfg_r.backoff_speed <= cfg_wdata[SPEED_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // state doubles as the result register: it only moves on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_IDLE;
      state_r.count       <= '0;
      state_r.timer_idle  <= 1'b1;
      state_r.cmd_a       <= '0;
      state_r.cmd_b       <= '0;
      state_r.guard_one   <= G_NONE;
      state_r.guard_two   <= G_NONE;
      state_r.bound_right <= '0;
      state_r.bound_top   <= '0;
      zero_r              <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
        zero_r  <= zero_nxt;
      end
      if (in_fire)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_a       = state_r.cmd_a.drive;
  assign out_dir_a         = state_r.cmd_a.dir;
  assign out_drive_b       = state_r.cmd_b.drive;
  assign out_dir_b         = state_r.cmd_b.dir;
  assign out_zero_encoders = zero_r;
  assign out_phase         = state_r.phase;
  assign out_guard_one     = state_r.guard_one;
  assign out_guard_two     = state_r.guard_two;
  assign out_right_limit   = state_r.bound_right;
  assign out_top_limit     = state_r.bound_top;
  assign out_finished      = (state_r.phase == PH_DONE);

endmodule
